// ----- hdl/tae_pkg.sv -----
// ----------------------------------------------------------------------------
// tae_pkg: shared types and constants of the tar entry extractor
// Header field offsets, phase encoding, result codes and the result struct.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int NAME_BYTES   = 100;
    localparam int SIZE_DIGITS  = 12;
    localparam int SIZE_AT      = 124;
    localparam int TYPE_AT      = 156;
    localparam int NAME_WORDS   = 13;

    localparam int LEN_W   = 40;
    localparam int SIZE_W  = 36;
    localparam int POS_W   = 9;
    localparam int NCNT_W  = 7;
    localparam int WIDX_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 64;

    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(BLOCK_BYTES - 1);
    localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(NAME_WORDS - 1);
    localparam logic [7:0]        CHAR_ZERO  = 8'h30;
    localparam logic [7:0]        CHAR_SPACE = 8'h20;

    // parse phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_PAD    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // end causes
    localparam logic [1:0] CAUSE_ZERO_HDR = 2'd0;
    localparam logic [1:0] CAUSE_OVERRUN  = 2'd1;
    localparam logic [1:0] CAUSE_SHORT    = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] word;
        logic [WIDX_W-1:0] widx;
        logic [NCNT_W-1:0] nlen;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] fbyte;
        logic              last;
        logic [1:0]        cause;
    } res_t;

    // name byte write request
    typedef struct packed {
        logic              en;
        logic [NCNT_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } nwr_t;

endpackage

// ----- hdl/tar_archive_entry_extractor.sv -----
// ----------------------------------------------------------------------------
// tar_archive_entry_extractor: streaming tar entry extractor
// Parses a tar archive byte stream and emits name words, file data bytes
// and an end marker.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | tdata[7:0] archive byte
//  m_*       | out       | tdata name word/index/length/size/byte/cause,
//            |           | tuser result kind, tlast entry last
//  cfg_*     | in        | data[39:0] archive length
//
//  One archive byte is taken per cycle while the parser is not stalled; each
//  byte passes an input register, the parser and a result register.
//  After the final byte of a regular file's header, input is held while the
//  name words leave one per cycle as m_tready allows, and for a deferred end marker.
//  A held result with m_tready low stalls the parser; the input register still takes one byte.
//  Reset is synchronous on aresetn low and needs no clearing pass.
// ----------------------------------------------------------------------------
module tar_archive_entry_extractor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] archive_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] name_word, [67:64] name_word_index,
                                    // [74:68] name_length, [110:75] entry_size,
                                    // [118:111] file_byte, [120:119] end_cause, rest 0
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast,   // entry_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [39:0]  cfg_data   // archive_length
);

    logic [tae_pkg::LEN_W-1:0]   len_reg;
    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        m_valid_reg;
    tae_pkg::res_t               m_res_reg;

    logic                        out_ready;
    logic                        consume;
    logic                        res_valid;
    tae_pkg::res_t               res;
    tae_pkg::nwr_t               name_wr;
    logic [tae_pkg::WIDX_W-1:0]  name_rd_idx;
    logic [tae_pkg::WORD_W-1:0]  name_rd_word;

    assign cfg_ready = 1'b1;
    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || consume;

    // hold the archive length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            len_reg <= cfg_data;
        end
    end

    // input register: load on request, drop when consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    tae_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .archive_length (len_reg),
        .in_valid       (in_valid_reg),
        .in_byte        (in_byte_reg),
        .out_ready      (out_ready),
        .consume        (consume),
        .res_valid      (res_valid),
        .res            (res),
        .name_wr        (name_wr),
        .name_rd_idx    (name_rd_idx),
        .name_rd_word   (name_rd_word)
    );

    tae_name_store u_name_store (
        .aclk    (aclk),
        .wr      (name_wr),
        .rd_idx  (name_rd_idx),
        .rd_word (name_rd_word)
    );

    // pack the result
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {7'd0, m_res_reg.cause, m_res_reg.fbyte, m_res_reg.size,
                       m_res_reg.nlen, m_res_reg.widx, m_res_reg.word};

endmodule

// ----- hdl/tae_name_store.sv -----
// ----------------------------------------------------------------------------
// tae_name_store: name byte store
// Thirteen 64-bit words written one byte lane at a time. The word for the
// next cycle is read into a register.
// ----------------------------------------------------------------------------
module tae_name_store (
    input  logic                         aclk,
    input  tae_pkg::nwr_t                wr,
    input  logic [tae_pkg::WIDX_W-1:0]   rd_idx,
    output logic [tae_pkg::WORD_W-1:0]   rd_word
);

    logic [tae_pkg::WORD_W-1:0] mem_reg [tae_pkg::NAME_WORDS];
    logic [tae_pkg::WORD_W-1:0] rd_word_reg;

    // write one byte lane of the addressed word
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr[tae_pkg::NCNT_W-1:3]][wr.addr[2:0]*8 +: 8] <= wr.data;
        end
    end

    // fetch the word emitted next cycle; an index past the last word reads zero
    always_ff @(posedge aclk) begin
        if (rd_idx <= tae_pkg::LAST_WORD) begin
            rd_word_reg <= mem_reg[rd_idx];
        end else begin
            rd_word_reg <= '0;
        end
    end

    assign rd_word = rd_word_reg;

endmodule

// ----- hdl/tae_parser.sv -----
// ----------------------------------------------------------------------------
// tae_parser: tar header and entry parser
// Steps one archive byte per cycle when not stalled, tracks header fields,
// emits name words, data bytes and the end marker one per ready output cycle.
// ----------------------------------------------------------------------------
module tae_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tae_pkg::LEN_W-1:0]   archive_length,
    input  logic                        in_valid,
    input  logic [7:0]                  in_byte,
    input  logic                        out_ready,
    output logic                        consume,
    output logic                        res_valid,
    output tae_pkg::res_t               res,
    output tae_pkg::nwr_t               name_wr,
    output logic [tae_pkg::WIDX_W-1:0]  name_rd_idx,
    input  logic [tae_pkg::WORD_W-1:0]  name_rd_word
);

    tae_pkg::phase_t              phase_reg, phase_next;
    logic [tae_pkg::LEN_W-1:0]    off_reg, off_next;
    logic [tae_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [tae_pkg::NCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         closed_reg, closed_next;
    logic [tae_pkg::SIZE_W-1:0]   acc_reg, acc_next;
    logic                         stop_reg, stop_next;
    logic [7:0]                   typ_reg, typ_next;
    logic                         hz_reg, hz_next;
    logic [tae_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic [tae_pkg::POS_W-1:0]    pad_reg, pad_next;
    logic                         regf_reg, regf_next;
    logic                         burst_reg, burst_next;
    logic [tae_pkg::WIDX_W-1:0]   widx_reg, widx_next;
    logic [tae_pkg::NCNT_W-1:0]   blen_reg, blen_next;
    logic                         endp_reg, endp_next;
    logic [1:0]                   cause_reg, cause_next;

    logic                         pending;
    logic                         emit_burst;
    logic                         emit_endp;
    logic [tae_pkg::LEN_W-1:0]    off_p1;
    logic [tae_pkg::LEN_W:0]      hdr_room;
    logic [tae_pkg::LEN_W+1:0]    entry_end;
    logic [tae_pkg::LEN_W:0]      next_hdr_end;
    logic [tae_pkg::LEN_W:0]      zero_size_end;
    logic                         is_octal;
    logic                         hdr_regular;
    logic                         data_last;
    logic [tae_pkg::POS_W-1:0]    pad_dec;
    logic [tae_pkg::WORD_W-1:0]   masked_word;

    assign pending    = burst_reg || endp_reg;
    assign consume    = in_valid && !pending && out_ready;
    assign emit_burst = burst_reg && out_ready;
    assign emit_endp  = !burst_reg && endp_reg && out_ready;

    assign off_p1        = off_reg + 1'b1;
    assign hdr_room      = {1'b0, off_reg} + (tae_pkg::LEN_W+1)'(tae_pkg::BLOCK_BYTES);
    assign next_hdr_end  = {1'b0, off_p1} +
                           {(tae_pkg::LEN_W+1-tae_pkg::POS_W)'(1'b1), pad_reg};
    assign zero_size_end = {1'b0, off_p1} + (tae_pkg::LEN_W+1)'(tae_pkg::BLOCK_BYTES);
    assign is_octal      = (in_byte[7:3] == tae_pkg::CHAR_ZERO[7:3]);
    assign data_last     = (rem_reg <= tae_pkg::SIZE_W'(1));
    assign pad_dec       = pad_reg - tae_pkg::POS_W'(pad_reg != '0);

    // fetch the name word that is emitted in the next cycle
    assign name_rd_idx   = widx_next;

    // zero the bytes past the name length
    always_comb begin
        masked_word = name_rd_word;
        for (int b = 0; b < 8; b++) begin
            if ({widx_reg, 3'(b)} >= blen_reg) begin
                masked_word[b*8 +: 8] = 8'h00;
            end
        end
    end

    // state update and result selection
    always_comb begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        closed_next = closed_reg;
        acc_next    = acc_reg;
        stop_next   = stop_reg;
        typ_next    = typ_reg;
        hz_next     = hz_reg;
        rem_next    = rem_reg;
        pad_next    = pad_reg;
        regf_next   = regf_reg;
        burst_next  = burst_reg;
        widx_next   = widx_reg;
        blen_next   = blen_reg;
        endp_next   = endp_reg;
        cause_next  = cause_reg;
        res_valid   = 1'b0;
        res         = '0;
        name_wr     = '0;
        hdr_regular = 1'b0;
        entry_end   = '0;

        if (emit_burst) begin
            // emit one name word
            res_valid = 1'b1;
            res.kind  = tae_pkg::KIND_NAME;
            res.word  = masked_word;
            res.widx  = widx_reg;
            res.nlen  = blen_reg;
            res.size  = rem_reg;
            res.last  = (widx_reg == tae_pkg::LAST_WORD) && (rem_reg == '0);
            widx_next = widx_reg + 1'b1;
            if (widx_reg == tae_pkg::LAST_WORD) begin
                burst_next = 1'b0;
            end
        end else if (emit_endp) begin
            // emit the deferred end marker
            res_valid = 1'b1;
            res.kind  = tae_pkg::KIND_END;
            res.cause = cause_reg;
            endp_next = 1'b0;
        end else if (consume) begin
            unique case (phase_reg)
                tae_pkg::PH_HEADER: begin
                    if (pos_reg == '0 && hdr_room > {1'b0, archive_length}) begin
                        // drop the byte, no room for a header
                        res_valid  = 1'b1;
                        res.kind   = tae_pkg::KIND_END;
                        res.cause  = tae_pkg::CAUSE_SHORT;
                        phase_next = tae_pkg::PH_DONE;
                    end else begin
                        if (in_byte != 8'h00) begin
                            hz_next = 1'b0;
                        end
                        // collect the name
                        if (pos_reg < tae_pkg::POS_W'(tae_pkg::NAME_BYTES) && !closed_reg) begin
                            if (in_byte == 8'h00) begin
                                closed_next = 1'b1;
                            end else if (cnt_reg < tae_pkg::NCNT_W'(tae_pkg::NAME_BYTES)) begin
                                name_wr.en   = 1'b1;
                                name_wr.addr = cnt_reg;
                                name_wr.data = in_byte;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        // decode the octal size
                        if (pos_reg >= tae_pkg::POS_W'(tae_pkg::SIZE_AT) &&
                            pos_reg < tae_pkg::POS_W'(tae_pkg::SIZE_AT + tae_pkg::SIZE_DIGITS) &&
                            !stop_reg) begin
                            if (in_byte == 8'h00 || in_byte == tae_pkg::CHAR_SPACE) begin
                                stop_next = 1'b1;
                            end else if (is_octal) begin
                                acc_next = {acc_reg[tae_pkg::SIZE_W-4:0], in_byte[2:0]};
                            end
                        end
                        if (pos_reg == tae_pkg::POS_W'(tae_pkg::TYPE_AT)) begin
                            typ_next = in_byte;
                        end
                        off_next = off_p1;
                        pos_next = pos_reg + 1'b1;

                        // header complete
                        if (pos_reg == tae_pkg::LAST_POS) begin
                            entry_end   = {2'b00, off_p1} + (tae_pkg::LEN_W+2)'(acc_next);
                            hdr_regular = (typ_next == 8'h00) || (typ_next == tae_pkg::CHAR_ZERO);
                            if (hz_next) begin
                                res_valid  = 1'b1;
                                res.kind   = tae_pkg::KIND_END;
                                res.cause  = tae_pkg::CAUSE_ZERO_HDR;
                                phase_next = tae_pkg::PH_DONE;
                            end else if (entry_end > {2'b00, archive_length}) begin
                                res_valid  = 1'b1;
                                res.kind   = tae_pkg::KIND_END;
                                res.cause  = tae_pkg::CAUSE_OVERRUN;
                                phase_next = tae_pkg::PH_DONE;
                            end else begin
                                regf_next = hdr_regular;
                                rem_next  = acc_next;
                                pad_next  = tae_pkg::POS_W'(-acc_next[tae_pkg::POS_W-1:0]);
                                blen_next = cnt_next;
                                if (hdr_regular) begin
                                    burst_next = 1'b1;
                                    widx_next  = '0;
                                end
                                if (acc_next == '0) begin
                                    if (zero_size_end > {1'b0, archive_length}) begin
                                        phase_next = tae_pkg::PH_DONE;
                                        if (hdr_regular) begin
                                            endp_next  = 1'b1;
                                            cause_next = tae_pkg::CAUSE_SHORT;
                                        end else begin
                                            res_valid = 1'b1;
                                            res.kind  = tae_pkg::KIND_END;
                                            res.cause = tae_pkg::CAUSE_SHORT;
                                        end
                                    end else begin
                                        phase_next  = tae_pkg::PH_HEADER;
                                        pos_next    = '0;
                                        cnt_next    = '0;
                                        closed_next = 1'b0;
                                        acc_next    = '0;
                                        stop_next   = 1'b0;
                                        typ_next    = '0;
                                        hz_next     = 1'b1;
                                    end
                                end else begin
                                    phase_next = tae_pkg::PH_DATA;
                                end
                            end
                        end
                    end
                end
                tae_pkg::PH_DATA: begin
                    off_next = off_p1;
                    rem_next = rem_reg - tae_pkg::SIZE_W'(rem_reg != '0);
                    if (regf_reg) begin
                        res_valid = 1'b1;
                        res.kind  = tae_pkg::KIND_DATA;
                        res.fbyte = in_byte;
                        res.last  = data_last;
                    end
                    // entry done: skip padding or end
                    if (data_last) begin
                        if (next_hdr_end > {1'b0, archive_length}) begin
                            phase_next = tae_pkg::PH_DONE;
                            if (regf_reg) begin
                                endp_next  = 1'b1;
                                cause_next = tae_pkg::CAUSE_SHORT;
                            end else begin
                                res_valid = 1'b1;
                                res.kind  = tae_pkg::KIND_END;
                                res.cause = tae_pkg::CAUSE_SHORT;
                            end
                        end else if (pad_reg != '0) begin
                            phase_next = tae_pkg::PH_PAD;
                        end else begin
                            phase_next  = tae_pkg::PH_HEADER;
                            pos_next    = '0;
                            cnt_next    = '0;
                            closed_next = 1'b0;
                            acc_next    = '0;
                            stop_next   = 1'b0;
                            typ_next    = '0;
                            hz_next     = 1'b1;
                        end
                    end
                end
                tae_pkg::PH_PAD: begin
                    off_next = off_p1;
                    pad_next = pad_dec;
                    if (pad_dec == '0) begin
                        phase_next  = tae_pkg::PH_HEADER;
                        pos_next    = '0;
                        cnt_next    = '0;
                        closed_next = 1'b0;
                        acc_next    = '0;
                        stop_next   = 1'b0;
                        typ_next    = '0;
                        hz_next     = 1'b1;
                    end
                end
                tae_pkg::PH_DONE: begin
                    // drop every byte after the end
                end
                default: begin
                    phase_next = tae_pkg::PH_DONE;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= tae_pkg::PH_HEADER;
            off_reg    <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            closed_reg <= 1'b0;
            acc_reg    <= '0;
            stop_reg   <= 1'b0;
            typ_reg    <= '0;
            hz_reg     <= 1'b1;
            rem_reg    <= '0;
            pad_reg    <= '0;
            regf_reg   <= 1'b0;
            burst_reg  <= 1'b0;
            widx_reg   <= '0;
            blen_reg   <= '0;
            endp_reg   <= 1'b0;
            cause_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            closed_reg <= closed_next;
            acc_reg    <= acc_next;
            stop_reg   <= stop_next;
            typ_reg    <= typ_next;
            hz_reg     <= hz_next;
            rem_reg    <= rem_next;
            pad_reg    <= pad_next;
            regf_reg   <= regf_next;
            burst_reg  <= burst_next;
            widx_reg   <= widx_next;
            blen_reg   <= blen_next;
            endp_reg   <= endp_next;
            cause_reg  <= cause_next;
        end
    end

    // the name word burst closes after the last word
    a_burst_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_burst && widx_reg == tae_pkg::LAST_WORD) |=> !burst_reg)
        else $error("name burst did not close after last word");

    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_reg |-> (widx_reg <= tae_pkg::LAST_WORD))
        else $error("name word index out of range");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tae_pkg::PH_DONE) |=> (phase_reg == tae_pkg::PH_DONE))
        else $error("parser left the finished phase");

    a_name_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= tae_pkg::NCNT_W'(tae_pkg::NAME_BYTES))
        else $error("name count beyond name field");

    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tae_pkg::PH_PAD) |-> (pad_reg != '0))
        else $error("pad phase with nothing to skip");

endmodule
